/* src/dbtt_pkg.sv */
// Shared types and constants for the DRAM bank timing tracker.
// Used by the register block, the controller, the datapath and the top level.
`default_nettype none

package dbtt_pkg;

    localparam int TIME_W = 48;
    localparam int CFG_W  = 20;
    localparam int NCFG   = 8;
    localparam int ADDR_W = 5;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Request kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Row hit kinds
    typedef enum logic [1:0] {
        HIT_CLOSED   = 2'd0,
        HIT_ROW      = 2'd1,
        HIT_CONFLICT = 2'd2
    } hit_t;

    // Register indexes
    typedef enum logic [2:0] {
        REG_PRECHARGE  = 3'd0,
        REG_ACT_ACCESS = 3'd1,
        REG_RD_PRE     = 3'd2,
        REG_WR_PRE     = 3'd3,
        REG_WR_RD      = 3'd4,
        REG_RD_WR      = 3'd5,
        REG_RD_DONE    = 3'd6,
        REG_WR_DONE    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] precharge_time;
        logic [CFG_W-1:0] activate_to_access;
        logic [CFG_W-1:0] read_to_precharge;
        logic [CFG_W-1:0] write_to_precharge;
        logic [CFG_W-1:0] write_to_read;
        logic [CFG_W-1:0] read_to_write;
        logic [CFG_W-1:0] read_done_delay;
        logic [CFG_W-1:0] write_done_delay;
    } cfg_t;

    // Operand selects of the shared add-and-max unit
    typedef enum logic [1:0] {
        BASE_ACC,
        BASE_NOW,
        BASE_ZERO
    } base_sel_t;

    typedef enum logic [2:0] {
        A_ACT,
        A_PRE,
        A_RD,
        A_WR,
        A_COL
    } a_sel_t;

    typedef enum logic [2:0] {
        B_RP,
        B_RCD,
        B_RPRE,
        B_WPRE,
        B_RD_GAP,
        B_WR_GAP,
        B_DONE
    } b_sel_t;

    typedef struct packed {
        logic      load;
        logic      load_entry;
        base_sel_t base_sel;
        a_sel_t    a_sel;
        b_sel_t    b_sel;
        logic      ld_pre;
        logic      ld_act;
        logic      ld_col;
        logic      commit;
    } cmd_t;

    typedef struct packed {
        hit_t hit;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* src/dbtt_regs.sv */
// APB-style configuration registers of the bank timing tracker.
// Depends on dbtt_pkg for the register struct and index codes.
`default_nettype none

module dbtt_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dbtt_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output dbtt_pkg::cfg_t                   cfg
);

    dbtt_pkg::cfg_t     cfg_reg;
    dbtt_pkg::reg_idx_t sel_idx;
    logic               wr_en;
    logic [dbtt_pkg::CFG_W-1:0] wval;
    logic [dbtt_pkg::CFG_W-1:0] rval;

    assign pready  = 1'b1;
    assign sel_idx = dbtt_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel & penable & pwrite;
    assign wval    = pwdata[dbtt_pkg::CFG_W-1:0];
    assign cfg     = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (sel_idx)
                dbtt_pkg::REG_PRECHARGE:  cfg_reg.precharge_time     <= wval;
                dbtt_pkg::REG_ACT_ACCESS: cfg_reg.activate_to_access <= wval;
                dbtt_pkg::REG_RD_PRE:     cfg_reg.read_to_precharge  <= wval;
                dbtt_pkg::REG_WR_PRE:     cfg_reg.write_to_precharge <= wval;
                dbtt_pkg::REG_WR_RD:      cfg_reg.write_to_read      <= wval;
                dbtt_pkg::REG_RD_WR:      cfg_reg.read_to_write      <= wval;
                dbtt_pkg::REG_RD_DONE:    cfg_reg.read_done_delay    <= wval;
                dbtt_pkg::REG_WR_DONE:    cfg_reg.write_done_delay   <= wval;
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (sel_idx)
            dbtt_pkg::REG_PRECHARGE:  rval = cfg_reg.precharge_time;
            dbtt_pkg::REG_ACT_ACCESS: rval = cfg_reg.activate_to_access;
            dbtt_pkg::REG_RD_PRE:     rval = cfg_reg.read_to_precharge;
            dbtt_pkg::REG_WR_PRE:     rval = cfg_reg.write_to_precharge;
            dbtt_pkg::REG_WR_RD:      rval = cfg_reg.write_to_read;
            dbtt_pkg::REG_RD_WR:      rval = cfg_reg.read_to_write;
            dbtt_pkg::REG_RD_DONE:    rval = cfg_reg.read_done_delay;
            dbtt_pkg::REG_WR_DONE:    rval = cfg_reg.write_done_delay;
            default:                  rval = '0;
        endcase
    end

    assign prdata = {{(32 - dbtt_pkg::CFG_W){1'b0}}, rval};

endmodule

`default_nettype wire

/* src/dbtt_ctrl.sv */
// Sequencer of the bank timing tracker: steps the shared add-and-max unit.
// Depends on dbtt_pkg for the command and status structs.
`default_nettype none

module dbtt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output dbtt_pkg::cmd_t         cmd,
    input  wire dbtt_pkg::status_t status
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_RD    = 10'b00_0000_0010,
        ST_PA    = 10'b00_0000_0100,
        ST_PB    = 10'b00_0000_1000,
        ST_PC    = 10'b00_0001_0000,
        ST_ACT_X = 10'b00_0010_0000,
        ST_ACT_C = 10'b00_0100_0000,
        ST_C1    = 10'b00_1000_0000,
        ST_C2    = 10'b01_0000_0000,
        ST_C3    = 10'b10_0000_0000
    } state_t;

    // Done step is a flag beside the state register, held until the output slot frees
    state_t state_reg, state_next;
    logic   done_reg, done_next;

    assign in_ready = (state_reg == ST_IDLE) && !done_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        if (done_reg)
        begin
            if (status.out_free)
            begin
                done_next = 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:  if (in_valid) state_next = ST_RD;
                ST_RD:
                begin
                    case (status.hit)
                        dbtt_pkg::HIT_CLOSED:   state_next = ST_ACT_C;
                        dbtt_pkg::HIT_CONFLICT: state_next = ST_PA;
                        default:                state_next = ST_C1;
                    endcase
                end
                ST_PA:    state_next = ST_PB;
                ST_PB:    state_next = ST_PC;
                ST_PC:    state_next = ST_ACT_X;
                ST_ACT_X: state_next = ST_C1;
                ST_ACT_C: state_next = ST_C1;
                ST_C1:    state_next = ST_C2;
                ST_C2:    state_next = ST_C3;
                ST_C3:
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                default:  state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Command decode
    always_comb
    begin
        cmd            = '0;
        cmd.base_sel   = dbtt_pkg::BASE_ACC;
        cmd.a_sel      = dbtt_pkg::A_ACT;
        cmd.b_sel      = dbtt_pkg::B_RP;
        cmd.load       = in_ready && in_valid;
        if (done_reg)
        begin
            cmd.base_sel = dbtt_pkg::BASE_ZERO;
            cmd.a_sel    = dbtt_pkg::A_COL;
            cmd.b_sel    = dbtt_pkg::B_DONE;
            cmd.commit   = status.out_free;
        end
        else
        begin
            case (state_reg)
                ST_RD: cmd.load_entry = 1'b1;
                ST_PA:
                begin
                    cmd.base_sel = dbtt_pkg::BASE_NOW;
                    cmd.a_sel    = dbtt_pkg::A_ACT;
                    cmd.b_sel    = dbtt_pkg::B_RP;
                end
                ST_PB:
                begin
                    cmd.a_sel = dbtt_pkg::A_RD;
                    cmd.b_sel = dbtt_pkg::B_RPRE;
                end
                ST_PC:
                begin
                    cmd.a_sel  = dbtt_pkg::A_WR;
                    cmd.b_sel  = dbtt_pkg::B_WPRE;
                    cmd.ld_pre = 1'b1;
                end
                ST_ACT_X:
                begin
                    cmd.base_sel = dbtt_pkg::BASE_ZERO;
                    cmd.a_sel    = dbtt_pkg::A_PRE;
                    cmd.ld_act   = 1'b1;
                end
                ST_ACT_C:
                begin
                    cmd.base_sel = dbtt_pkg::BASE_NOW;
                    cmd.a_sel    = dbtt_pkg::A_PRE;
                    cmd.ld_act   = 1'b1;
                end
                ST_C1:
                begin
                    cmd.base_sel = dbtt_pkg::BASE_NOW;
                    cmd.a_sel    = dbtt_pkg::A_ACT;
                    cmd.b_sel    = dbtt_pkg::B_RCD;
                end
                ST_C2:
                begin
                    cmd.a_sel = dbtt_pkg::A_RD;
                    cmd.b_sel = dbtt_pkg::B_RD_GAP;
                end
                ST_C3:
                begin
                    cmd.a_sel  = dbtt_pkg::A_WR;
                    cmd.b_sel  = dbtt_pkg::B_WR_GAP;
                    cmd.ld_col = 1'b1;
                end
                default: cmd.load_entry = 1'b0;
            endcase
        end
    end

    // A result is only committed into a free output slot
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("commit into a full output register");

    // An accepted item goes straight to the entry read
    a_load_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_RD))
        else $error("entry read skipped after accept");

    // No new item while a result is being committed
    a_load_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !cmd.commit)
        else $error("accept and commit in one cycle");

endmodule

`default_nettype wire

/* src/dbtt_dpath.sv */
// Datapath of the bank timing tracker: bank state memory, working registers,
// shared saturating add-and-max unit and output register. Depends on dbtt_pkg.
`default_nettype none

module dbtt_dpath #(
    parameter int RANKS     = 2,
    parameter int BANKS     = 8,
    parameter int ROW_BITS  = 16,
    parameter int BURST_GAP = 5000
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire dbtt_pkg::cmd_t              cmd,
    output dbtt_pkg::status_t                status,
    input  wire dbtt_pkg::cfg_t              cfg,
    input  wire logic                        operation,
    input  wire logic                        rank_index,
    input  wire logic [2:0]                  bank_index,
    input  wire logic [15:0]                 row_address,
    input  wire logic [dbtt_pkg::TIME_W-1:0] current_time,
    input  wire logic [15:0]                 request_tag,
    input  wire logic [63:0]                 request_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [15:0]                      tag_out,
    output logic [63:0]                      data_out,
    output logic [dbtt_pkg::TIME_W-1:0]      column_time,
    output logic [dbtt_pkg::TIME_W-1:0]      done_time,
    output logic [1:0]                       hit_kind
);

    localparam int NBANK = RANKS * BANKS;
    localparam int IDX_W = (NBANK > 1) ? $clog2(NBANK) : 1;
    localparam int TW    = dbtt_pkg::TIME_W;
    localparam int CW    = dbtt_pkg::CFG_W;
    localparam logic [CW-1:0] GAP = CW'(BURST_GAP);

    // Bank state memory
    logic [ROW_BITS-1:0] row_mem [NBANK];
    logic [TW-1:0]       act_mem [NBANK];
    logic [TW-1:0]       pre_mem [NBANK];
    logic [TW-1:0]       rd_mem  [NBANK];
    logic [TW-1:0]       wr_mem  [NBANK];
    logic [NBANK-1:0]    open_reg;

    logic [ROW_BITS-1:0] row_rdata;
    logic [TW-1:0]       act_rdata, pre_rdata, rd_rdata, wr_rdata;

    // Latched request
    logic                op_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic [TW-1:0]       now_reg;
    logic [15:0]         tag_reg;
    logic [63:0]         data_reg;

    // Working registers
    logic [TW-1:0]       act_reg, pre_reg, rd_reg, wr_reg, col_reg, acc_reg;
    dbtt_pkg::hit_t      hit_reg;
    dbtt_pkg::hit_t      hit_now;

    logic [IDX_W-1:0]    idx_in;
    logic [ROW_BITS-1:0] row_in;

    logic [TW-1:0]       a_val, base_val, sat_val, result;
    logic [CW-1:0]       b_val;
    logic [TW:0]         sum;

    logic                out_valid_reg;

    // Bank index: rank and bank wrapped into range through a constant table
    always_comb
    begin
        idx_in = '0;
        for (int r = 0; r < 2; r++)
            for (int b = 0; b < 8; b++)
                if ({rank_index, bank_index} == 4'(r * 8 + b))
                    idx_in = IDX_W'((r % RANKS) * BANKS + (b % BANKS));
    end

    assign row_in   = ROW_BITS'(row_address);

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            idx_reg  <= idx_in;
            row_reg  <= row_in;
            now_reg  <= current_time;
            tag_reg  <= request_tag;
            data_reg <= request_data;
        end
    end

    // Memory read on accept, write on commit
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            row_rdata <= row_mem[idx_in];
            act_rdata <= act_mem[idx_in];
            pre_rdata <= pre_mem[idx_in];
            rd_rdata  <= rd_mem[idx_in];
            wr_rdata  <= wr_mem[idx_in];
        end
        if (cmd.commit)
        begin
            row_mem[idx_reg] <= row_reg;
            act_mem[idx_reg] <= act_reg;
            pre_mem[idx_reg] <= pre_reg;
            rd_mem[idx_reg]  <= (op_reg == dbtt_pkg::OP_READ)  ? col_reg : rd_reg;
            wr_mem[idx_reg]  <= (op_reg == dbtt_pkg::OP_WRITE) ? col_reg : wr_reg;
        end
    end

    // Open flags double as valid bits: a closed bank holds reset times
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else if (cmd.commit)
        begin
            open_reg[idx_reg] <= 1'b1;
        end
    end

    // Row hit classification
    always_comb
    begin
        if (!open_reg[idx_reg])
        begin
            hit_now = dbtt_pkg::HIT_CLOSED;
        end
        else if (row_rdata != row_reg)
        begin
            hit_now = dbtt_pkg::HIT_CONFLICT;
        end
        else
        begin
            hit_now = dbtt_pkg::HIT_ROW;
        end
    end

    assign status.hit      = hit_now;
    assign status.out_free = !out_valid_reg || out_ready;

    // Operand selection
    always_comb
    begin
        case (cmd.a_sel)
            dbtt_pkg::A_ACT: a_val = act_reg;
            dbtt_pkg::A_PRE: a_val = pre_reg;
            dbtt_pkg::A_RD:  a_val = rd_reg;
            dbtt_pkg::A_WR:  a_val = wr_reg;
            dbtt_pkg::A_COL: a_val = col_reg;
            default:         a_val = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.b_sel)
            dbtt_pkg::B_RP:     b_val = cfg.precharge_time;
            dbtt_pkg::B_RCD:    b_val = cfg.activate_to_access;
            dbtt_pkg::B_RPRE:   b_val = cfg.read_to_precharge;
            dbtt_pkg::B_WPRE:   b_val = cfg.write_to_precharge;
            dbtt_pkg::B_RD_GAP: b_val = (op_reg == dbtt_pkg::OP_READ) ? GAP
                                                                      : cfg.read_to_write;
            dbtt_pkg::B_WR_GAP: b_val = (op_reg == dbtt_pkg::OP_READ) ? cfg.write_to_read
                                                                      : GAP;
            dbtt_pkg::B_DONE:   b_val = (op_reg == dbtt_pkg::OP_READ) ? cfg.read_done_delay
                                                                      : cfg.write_done_delay;
            default:            b_val = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.base_sel)
            dbtt_pkg::BASE_ACC: base_val = acc_reg;
            dbtt_pkg::BASE_NOW: base_val = now_reg;
            default:            base_val = '0;
        endcase
    end

    // Saturating add, then maximum against the base
    assign sum     = {1'b0, a_val} + {{(TW + 1 - CW){1'b0}}, b_val};
    assign sat_val = sum[TW] ? dbtt_pkg::TIME_MAX : sum[TW-1:0];
    assign result  = (sat_val > base_val) ? sat_val : base_val;

    // Working registers
    always_ff @(posedge clk)
    begin
        acc_reg <= result;
        if (cmd.load_entry)
        begin
            hit_reg <= hit_now;
            act_reg <= open_reg[idx_reg] ? act_rdata : '0;
            pre_reg <= open_reg[idx_reg] ? pre_rdata : '0;
            rd_reg  <= open_reg[idx_reg] ? rd_rdata  : '0;
            wr_reg  <= open_reg[idx_reg] ? wr_rdata  : '0;
        end
        if (cmd.ld_pre)
        begin
            pre_reg <= result;
        end
        if (cmd.ld_act)
        begin
            act_reg <= result;
        end
        if (cmd.ld_col)
        begin
            col_reg <= result;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            tag_out     <= tag_reg;
            data_out    <= data_reg;
            column_time <= col_reg;
            done_time   <= result;
            hit_kind    <= hit_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // The column command never issues before the request arrives
    a_col_after_now: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (col_reg >= now_reg))
        else $error("column time before arrival");

    // Completion never precedes the column command
    a_done_after_col: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (result >= col_reg))
        else $error("done time before column time");

    // A committed bank is open afterwards and a result is presented
    a_commit_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (open_reg[$past(idx_reg)] && out_valid_reg))
        else $error("commit did not open bank or present result");

endmodule

`default_nettype wire

/* src/dram_bank_timing_tracker_top.sv */
// Steps on the one shared add-and-max unit: an accepted item reads its bank
// entry, then runs PA, PB, PC and ACT_X on a row conflict or ACT_C on a closed
// bank, then C1, C2, C3 and a done step; one item is in work at a time. A
// result waiting in the output register does not block the next accept.
// Reset: config registers clear to 0, all banks precharged; no clearing pass.
// Top level: ties together dbtt_regs, dbtt_ctrl and dbtt_dpath (dbtt_pkg).
`default_nettype none

module dram_bank_timing_tracker_top #(
    parameter int RANKS     = 2,
    parameter int BANKS     = 8,
    parameter int ROW_BITS  = 16,
    parameter int BURST_GAP = 5000
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dbtt_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        operation,
    input  wire logic                        rank_index,
    input  wire logic [2:0]                  bank_index,
    input  wire logic [15:0]                 row_address,
    input  wire logic [dbtt_pkg::TIME_W-1:0] current_time,
    input  wire logic [15:0]                 request_tag,
    input  wire logic [63:0]                 request_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [15:0]                      tag_out,
    output logic [63:0]                      data_out,
    output logic [dbtt_pkg::TIME_W-1:0]      column_time,
    output logic [dbtt_pkg::TIME_W-1:0]      done_time,
    output logic [1:0]                       hit_kind
);

    dbtt_pkg::cfg_t    cfg;
    dbtt_pkg::cmd_t    cmd;
    dbtt_pkg::status_t status;

    dbtt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dbtt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    dbtt_dpath #(
        .RANKS     (RANKS),
        .BANKS     (BANKS),
        .ROW_BITS  (ROW_BITS),
        .BURST_GAP (BURST_GAP)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg          (cfg),
        .operation    (operation),
        .rank_index   (rank_index),
        .bank_index   (bank_index),
        .row_address  (row_address),
        .current_time (current_time),
        .request_tag  (request_tag),
        .request_data (request_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .tag_out      (tag_out),
        .data_out     (data_out),
        .column_time  (column_time),
        .done_time    (done_time),
        .hit_kind     (hit_kind)
    );

endmodule

`default_nettype wire
